[hw/rtl/coap_pkg.sv]
// Shared types and constants of the CoAP message parser.
package coap_pkg;

   // Parse phase of the byte stream.
   typedef enum logic [3:0] {
      PH_HEADER  = 4'd0,
      PH_TOKEN   = 4'd1,
      PH_OPTION  = 4'd2,
      PH_D13     = 4'd3,
      PH_D14A    = 4'd4,
      PH_D14B    = 4'd5,
      PH_L13     = 4'd6,
      PH_L14A    = 4'd7,
      PH_L14B    = 4'd8,
      PH_VALUE   = 4'd9,
      PH_PAYLOAD = 4'd10,
      PH_IGNORE  = 4'd11
   } phase_type;

   // Result word kind.
   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_TOKEN   = 3'd1,
      KIND_OPTION  = 3'd2,
      KIND_VALUE   = 3'd3,
      KIND_PAYLOAD = 3'd4,
      KIND_FIN     = 3'd5
   } kind_type;

   localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
   localparam logic [3:0]  NIBBLE_EXT8    = 4'd13;
   localparam logic [3:0]  NIBBLE_EXT16   = 4'd14;
   localparam logic [15:0] EXT8_BASE      = 16'd13;
   localparam logic [15:0] EXT16_BASE     = 16'd269;
   localparam logic [1:0]  HEADER_LAST    = 2'd3;

   // Result queue geometry.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_LVL_W = 3;

   // Parser state whose width does not follow a parameter.
   typedef struct packed {
      phase_type   phase;
      logic [1:0]  header_count;
      logic [23:0] header_hold;
      logic [3:0]  token_total;
      logic [3:0]  token_count;
      logic [15:0] option_sum;
      logic [3:0]  length_nibble;
      logic [7:0]  extension_hold;
      logic [15:0] value_remaining;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:           PH_HEADER,
      header_count:    2'd0,
      header_hold:     24'd0,
      token_total:     4'd0,
      token_count:     4'd0,
      option_sum:      16'd0,
      length_nibble:   4'd0,
      extension_hold:  8'd0,
      value_remaining: 16'd0
   };

   // One result word.
   typedef struct packed {
      kind_type    kind;
      logic [1:0]  version;
      logic [1:0]  msg_type;
      logic [3:0]  token_length;
      logic [7:0]  code;
      logic [15:0] message_id;
      logic [7:0]  data_value;
      logic [15:0] option_number;
      logic [15:0] value_length;
      logic [4:0]  item_index;
      logic        status;
      logic        last_result;
   } rsp_item_type;

   // Results caused by one input byte, packed to the front.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first_item;
      rsp_item_type second_item;
   } step_out_type;

endpackage

[hw/rtl/coap_step.sv]
// Per-byte next state and result words of the CoAP parser.
module coap_step #(
   parameter int MAX_TOKEN         = 8,
   parameter int MAX_OPTIONS       = 16,
   parameter int MAX_MESSAGE_BYTES = 2048,
   parameter int OPT_W             = $clog2(MAX_OPTIONS + 1),
   parameter int PAY_W             = $clog2(MAX_MESSAGE_BYTES)
) (
   input  coap_pkg::state_type    st,
   input  logic [OPT_W-1:0]       ocnt,
   input  logic [PAY_W-1:0]       pcnt,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output coap_pkg::state_type    st_in,
   output logic [OPT_W-1:0]       ocnt_in,
   output logic [PAY_W-1:0]       pcnt_in,
   output coap_pkg::step_out_type step_out
);
   import coap_pkg::*;

   logic [3:0]       delta;
   logic             opt_room;
   logic             skip;
   logic             delta_done;
   logic             len_done;
   logic             fin;
   logic [3:0]       nib;
   logic [15:0]      fin_len;
   logic [15:0]      sum_add;
   logic [15:0]      sum_next;
   logic [15:0]      vr_dec;
   phase_type        phase_mid;
   logic [OPT_W-1:0] ocnt_mid;
   logic [PAY_W-1:0] pcnt_mid;
   logic             err;
   rsp_item_type     r0;
   rsp_item_type     r1;
   logic             r0_valid;

   assign delta    = data_byte[7:4];
   assign opt_room = (ocnt < OPT_W'(MAX_OPTIONS));

   // Decode what this byte completes.
   always_comb begin
      skip = last_byte &&
             ((st.phase inside {PH_D13, PH_D14A, PH_D14B, PH_L13, PH_L14A, PH_L14B}) ||
              (st.phase == PH_OPTION && data_byte != PAYLOAD_MARKER && opt_room));
      delta_done = !skip &&
                   ((st.phase == PH_OPTION && data_byte != PAYLOAD_MARKER && opt_room &&
                     delta != NIBBLE_EXT8 && delta != NIBBLE_EXT16) ||
                    st.phase == PH_D13 || st.phase == PH_D14B);
      len_done = !skip && (st.phase == PH_L13 || st.phase == PH_L14B);
      nib      = (st.phase == PH_OPTION) ? data_byte[3:0] : st.length_nibble;
      fin      = (delta_done && nib != NIBBLE_EXT8 && nib != NIBBLE_EXT16) || len_done;
      case (st.phase)
         PH_L13:  fin_len = EXT8_BASE + {8'd0, data_byte};
         PH_L14B: fin_len = {st.extension_hold, data_byte} + EXT16_BASE;
         default: fin_len = {12'd0, nib};
      endcase
      case (st.phase)
         PH_D13:  sum_add = EXT8_BASE + {8'd0, data_byte};
         PH_D14B: sum_add = EXT16_BASE + {st.extension_hold, data_byte};
         default: sum_add = {12'd0, delta};
      endcase
      sum_next = delta_done ? (st.option_sum + sum_add) : st.option_sum;
      vr_dec   = (st.value_remaining != 16'd0) ? (st.value_remaining - 16'd1)
                                               : st.value_remaining;
   end

   // Next state.
   always_comb begin
      st_in    = st;
      ocnt_mid = ocnt;
      pcnt_mid = pcnt;
      if (!skip) begin
         unique case (st.phase)
            PH_HEADER: begin
               if (st.header_count != HEADER_LAST) begin
                  st_in.header_hold  = {st.header_hold[15:0], data_byte};
                  st_in.header_count = st.header_count + 2'd1;
               end else begin
                  st_in.token_total  = st.header_hold[19:16];
                  st_in.token_count  = 4'd0;
                  st_in.header_count = 2'd0;
                  st_in.phase = (st.header_hold[19:16] != 4'd0) ? PH_TOKEN : PH_OPTION;
               end
            end
            PH_TOKEN: begin
               st_in.token_count = st.token_count + 4'd1;
               if ((st.token_count + 4'd1) >= st.token_total) st_in.phase = PH_OPTION;
            end
            PH_OPTION: begin
               if (data_byte == PAYLOAD_MARKER) begin
                  st_in.phase = PH_PAYLOAD;
               end else if (!opt_room) begin
                  st_in.phase = PH_IGNORE;
               end else begin
                  st_in.length_nibble = data_byte[3:0];
                  if (delta == NIBBLE_EXT8) st_in.phase = PH_D13;
                  else if (delta == NIBBLE_EXT16) st_in.phase = PH_D14A;
               end
            end
            PH_D14A: begin
               st_in.extension_hold = data_byte;
               st_in.phase          = PH_D14B;
            end
            PH_L14A: begin
               st_in.extension_hold = data_byte;
               st_in.phase          = PH_L14B;
            end
            PH_VALUE: begin
               st_in.value_remaining = vr_dec;
               if (vr_dec == 16'd0) st_in.phase = PH_OPTION;
            end
            PH_PAYLOAD: begin
               if (pcnt != PAY_W'(MAX_MESSAGE_BYTES - 1)) pcnt_mid = pcnt + 1'b1;
            end
            default: begin
            end
         endcase
         st_in.option_sum = sum_next;
         if (delta_done) begin
            if (nib == NIBBLE_EXT8) st_in.phase = PH_L13;
            else if (nib == NIBBLE_EXT16) st_in.phase = PH_L14A;
         end
         if (fin) begin
            ocnt_mid = ocnt + 1'b1;
            if (fin_len == 16'd0) begin
               st_in.phase = PH_OPTION;
            end else begin
               st_in.value_remaining = fin_len;
               st_in.phase           = PH_VALUE;
            end
         end
      end
      phase_mid = st_in.phase;
      ocnt_in   = ocnt_mid;
      pcnt_in   = pcnt_mid;
      if (last_byte) begin
         st_in   = STATE_RESET;
         ocnt_in = '0;
         pcnt_in = '0;
      end
   end

   // Result words.
   always_comb begin
      r0       = '0;
      r1       = '0;
      r0_valid = 1'b0;
      if (!skip) begin
         unique case (st.phase)
            PH_HEADER: begin
               if (st.header_count == HEADER_LAST) begin
                  r0_valid        = 1'b1;
                  r0.kind         = KIND_HEADER;
                  r0.version      = st.header_hold[23:22];
                  r0.msg_type     = st.header_hold[21:20];
                  r0.token_length = st.header_hold[19:16];
                  r0.code         = st.header_hold[15:8];
                  r0.message_id   = {st.header_hold[7:0], data_byte};
               end
            end
            PH_TOKEN: begin
               if (st.token_count < 4'(MAX_TOKEN)) begin
                  r0_valid      = 1'b1;
                  r0.kind       = KIND_TOKEN;
                  r0.data_value = data_byte;
                  r0.item_index = 5'(st.token_count);
               end
            end
            PH_VALUE: begin
               r0_valid         = 1'b1;
               r0.kind          = KIND_VALUE;
               r0.data_value    = data_byte;
               r0.option_number = st.option_sum;
               r0.item_index    = 5'(ocnt - 1'b1);
            end
            PH_PAYLOAD: begin
               r0_valid      = 1'b1;
               r0.kind       = KIND_PAYLOAD;
               r0.data_value = data_byte;
            end
            default: begin
            end
         endcase
         if (fin) begin
            r0_valid         = 1'b1;
            r0.kind          = KIND_OPTION;
            r0.option_number = sum_next;
            r0.value_length  = fin_len;
            r0.item_index    = 5'(ocnt);
         end
      end
      r0.last_result = !last_byte;

      err = last_byte && (skip || phase_mid inside {PH_HEADER, PH_TOKEN, PH_VALUE});
      r1.kind         = KIND_FIN;
      r1.value_length = 16'(pcnt_mid);
      r1.item_index   = 5'(ocnt_mid);
      r1.status       = err;
      r1.last_result  = 1'b1;

      step_out.count       = {1'b0, r0_valid} + {1'b0, last_byte};
      step_out.first_item  = r0_valid ? r0 : r1;
      step_out.second_item = r1;
   end

endmodule

[hw/rtl/coap_rsp_fifo.sv]
// Result queue that takes up to two words a cycle and delivers one.
module coap_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        push_count,
   input  coap_pkg::rsp_item_type            push_a,
   input  coap_pkg::rsp_item_type            push_b,
   input  logic                              pop,
   output coap_pkg::rsp_item_type            head,
   output logic [coap_pkg::RSP_LVL_W-1:0]    level
);
   import coap_pkg::*;

   rsp_item_type         mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_in;
   logic [RSP_LVL_W-1:0] level_ff;
   logic [RSP_LVL_W-1:0] level_in;
   logic [RSP_PTR_W-1:0] wr_next_addr;

   assign wr_next_addr = wr_ptr_ff + 1'b1;
   assign wr_ptr_in    = wr_ptr_ff + RSP_PTR_W'(push_count);
   assign rd_ptr_in    = rd_ptr_ff + RSP_PTR_W'(pop);
   assign level_in     = level_ff + RSP_LVL_W'(push_count) - RSP_LVL_W'(pop);
   assign level        = level_ff;
   assign head         = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem[wr_ptr_ff] <= push_a;
      if (push_count == 2'd2) mem[wr_next_addr] <= push_b;
   end

endmodule

[hw/rtl/coap_message_parser_core.sv]
// Top level of the streaming CoAP message parser.
//
//  channel | dir | word                         | accepted when
//  --------+-----+------------------------------+---------------------------
//  req_    | in  | one message byte, tlast=end  | req_tvalid && req_tready
//  rsp_    | out | one parse result, tuser=kind | rsp_tvalid && rsp_tready
//
// Each accepted byte updates the parser state in the same cycle and pushes
// zero, one or two result words into a four-word queue; the first word is
// visible on rsp_ in the cycle after its byte is taken into an empty queue.
// One byte per cycle is sustained while results drain at one word per cycle;
// a byte that also ends the message adds an end word, and req_tready drops
// only when the queue lacks room for two. Synchronous reset returns the
// parser to the header phase and empties the queue.
module coap_message_parser_core #(
   parameter int MAX_TOKEN         = 8,
   parameter int MAX_OPTIONS       = 16,
   parameter int MAX_MESSAGE_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] version, [3:2] msg_type, [7:4] token_length, [15:8] code,
   // [31:16] message_id, [39:32] data_value, [55:40] option_number,
   // [71:56] value_length, [76:72] item_index, [77] status, [79:78] zero
   output logic [79:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last_result
);
   import coap_pkg::*;

   localparam int OPT_W = $clog2(MAX_OPTIONS + 1);
   localparam int PAY_W = $clog2(MAX_MESSAGE_BYTES);

   state_type            st_ff;
   state_type            st_in;
   logic [OPT_W-1:0]     ocnt_ff;
   logic [OPT_W-1:0]     ocnt_in;
   logic [PAY_W-1:0]     pcnt_ff;
   logic [PAY_W-1:0]     pcnt_in;
   step_out_type         step_out;
   logic                 req_accept;
   logic                 rsp_accept;
   logic [1:0]           push_count;
   rsp_item_type         head;
   logic [RSP_LVL_W-1:0] level;

   // Take a byte only while the queue can absorb a two-word result.
   assign req_tready = (level <= RSP_LVL_W'(RSP_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign push_count = req_accept ? step_out.count : 2'd0;

   coap_step #(
      .MAX_TOKEN         (MAX_TOKEN),
      .MAX_OPTIONS       (MAX_OPTIONS),
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
      .OPT_W             (OPT_W),
      .PAY_W             (PAY_W)
   ) u_step (
      .st        (st_ff),
      .ocnt      (ocnt_ff),
      .pcnt      (pcnt_ff),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .st_in     (st_in),
      .ocnt_in   (ocnt_in),
      .pcnt_in   (pcnt_in),
      .step_out  (step_out)
   );

   // Hold the parser state between bytes; advance only on an accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= STATE_RESET;
         ocnt_ff <= '0;
         pcnt_ff <= '0;
      end else if (req_accept) begin
         st_ff   <= st_in;
         ocnt_ff <= ocnt_in;
         pcnt_ff <= pcnt_in;
      end
   end

   coap_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_a     (step_out.first_item),
      .push_b     (step_out.second_item),
      .pop        (rsp_accept),
      .head       (head),
      .level      (level)
   );

   // Present the queue head on the result channel.
   assign rsp_tvalid = (level != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last_result;
   assign rsp_tdata  = {2'b00, head.status, head.item_index, head.value_length,
                        head.option_number, head.data_value, head.message_id,
                        head.code, head.token_length, head.msg_type, head.version};

   // The queue never holds more words than it has entries.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= RSP_LVL_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // A final byte leaves the parser in its reset state.
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=>
         (st_ff.phase == PH_HEADER && ocnt_ff == '0 && pcnt_ff == '0))
      else $error("parser state not cleared after message end");

   // An end word always closes the results of its byte.
   a_fin_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_FIN) |-> rsp_tlast)
      else $error("end word without last mark");

   // Counters stay within their saturation limits.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (ocnt_ff <= OPT_W'(MAX_OPTIONS)) &&
      (pcnt_ff <= PAY_W'(MAX_MESSAGE_BYTES - 1)))
      else $error("option or payload count out of range");

endmodule

[bench/coap_message_parser_core_test.sv]
// Self-checking testbench of the streaming CoAP message parser.
module coap_message_parser_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import coap_pkg::*;

   localparam int TOKEN_KEEP    = 8;
   localparam int OPTION_LIMIT  = 16;
   localparam int MESSAGE_LIMIT = 2048;
   localparam int PAYLOAD_CAP   = MESSAGE_LIMIT - 1;
   localparam int RANDOM_BYTES  = 1270;
   localparam int HOLD_CYCLES   = 250;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 20;

   // One scripted byte; where typed is set, the end word of the message is
   // given here directly instead of coming from the parse model.
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic        status;
      logic [4:0]  count;
      logic [15:0] plen;
   } script_row_type;

   localparam int SCRIPT_LEN = 28;
   localparam script_row_type SCRIPT [0:SCRIPT_LEN-1] = '{
      // single byte: message ends inside the header
      '{8'h40, 1'b1, 1'b1, 1'b1, 5'd0, 16'd0},
      // v1 non-confirmable, one token byte, code 0x01, id 0x1234
      '{8'h51, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h01, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h12, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h34, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'hAA, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      // one-byte delta extension, length 1, one value byte
      '{8'hD1, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h05, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h77, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      // two-byte delta extension, empty value
      '{8'hE0, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h01, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h02, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      // payload marker and one payload byte: success, two options
      '{8'hFF, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 5'd2, 16'd1},
      // all-ones header: 15-byte token cut short right after the header
      '{8'hFF, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'hFF, 1'b1, 1'b1, 1'b1, 5'd0, 16'd0},
      // bare marker as final byte: success with an empty payload
      '{8'h40, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'hFF, 1'b1, 1'b1, 1'b0, 5'd0, 16'd0},
      // literal delta 15 as final byte: option header without successor
      '{8'h40, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0},
      '{8'hF1, 1'b1, 1'b1, 1'b1, 5'd0, 16'd0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [1:0] version, [3:2] msg_type, [7:4] token_length, [15:8] code,
   // [31:16] message_id, [39:32] data_value, [55:40] option_number,
   // [71:56] value_length, [76:72] item_index, [77] status, [79:78] zero
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;            // [2:0] kind
   logic        rsp_tlast;            // last_result

   logic        stall_hold = 1'b0;
   int          fault_count = 0;

   // Result words still owed by the parser, oldest first.
   rsp_item_type pending_words[$];
   // Bytes of the message being sent.
   logic [7:0]   msg_bytes[$];

   // Parse state of the model.
   phase_type   ps_phase;
   logic [1:0]  ps_hdr_count;
   logic [23:0] ps_hdr_hold;
   logic [3:0]  ps_tok_total;
   logic [3:0]  ps_tok_count;
   logic [15:0] ps_opt_sum;
   logic [3:0]  ps_len_nib;
   logic [7:0]  ps_ext_hold;
   logic [15:0] ps_remaining;
   logic [4:0]  ps_opt_count;
   logic [10:0] ps_pay_count;

   coap_message_parser_core #(
      .MAX_TOKEN        (TOKEN_KEEP),
      .MAX_OPTIONS      (OPTION_LIMIT),
      .MAX_MESSAGE_BYTES(MESSAGE_LIMIT)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Return the model to the header phase, as after the end word.
   function automatic void reset_parser();
      ps_phase     = PH_HEADER;
      ps_hdr_count = '0;
      ps_hdr_hold  = '0;
      ps_tok_total = '0;
      ps_tok_count = '0;
      ps_opt_sum   = '0;
      ps_len_nib   = '0;
      ps_ext_hold  = '0;
      ps_remaining = '0;
      ps_opt_count = '0;
      ps_pay_count = '0;
   endfunction

   // Advance the model by one byte and queue the words it owes.
   function automatic void parse_byte(input logic [7:0] b, input logic last);
      rsp_item_type w;
      logic         err;
      logic         skip;
      logic         delta_done;
      logic         opt_done;
      logic [15:0]  opt_len;
      int           first;
      first      = pending_words.size();
      err        = 1'b0;
      skip       = 1'b0;
      delta_done = 1'b0;
      opt_done   = 1'b0;
      opt_len    = '0;

      // A final byte inside an option header drops that option.
      if (last) begin
         if (ps_phase >= PH_D13 && ps_phase <= PH_L14B) begin
            err  = 1'b1;
            skip = 1'b1;
         end
         if (ps_phase == PH_OPTION && b != PAYLOAD_MARKER && ps_opt_count < OPTION_LIMIT) begin
            err  = 1'b1;
            skip = 1'b1;
         end
      end

      if (!skip) begin
         case (ps_phase)
            PH_HEADER: begin
               if (ps_hdr_count < HEADER_LAST) begin
                  ps_hdr_hold  = {ps_hdr_hold[15:0], b};
                  ps_hdr_count = ps_hdr_count + 2'd1;
               end else begin
                  w              = '0;
                  w.kind         = KIND_HEADER;
                  w.version      = ps_hdr_hold[23:22];
                  w.msg_type     = ps_hdr_hold[21:20];
                  w.token_length = ps_hdr_hold[19:16];
                  w.code         = ps_hdr_hold[15:8];
                  w.message_id   = {ps_hdr_hold[7:0], b};
                  pending_words.push_back(w);
                  ps_tok_total = ps_hdr_hold[19:16];
                  ps_tok_count = '0;
                  ps_hdr_count = '0;
                  if (ps_tok_total != 0) ps_phase = PH_TOKEN;
                  else ps_phase = PH_OPTION;
               end
            end
            PH_TOKEN: begin
               // token bytes past the kept ones are swallowed silently
               if (ps_tok_count < TOKEN_KEEP) begin
                  w            = '0;
                  w.kind       = KIND_TOKEN;
                  w.data_value = b;
                  w.item_index = 5'(ps_tok_count);
                  pending_words.push_back(w);
               end
               ps_tok_count = ps_tok_count + 4'd1;
               if (ps_tok_count >= ps_tok_total) ps_phase = PH_OPTION;
            end
            PH_OPTION: begin
               if (b == PAYLOAD_MARKER) begin
                  ps_phase = PH_PAYLOAD;
               end else if (ps_opt_count >= OPTION_LIMIT) begin
                  ps_phase = PH_IGNORE;
               end else begin
                  ps_len_nib = b[3:0];
                  if (b[7:4] == NIBBLE_EXT8) ps_phase = PH_D13;
                  else if (b[7:4] == NIBBLE_EXT16) ps_phase = PH_D14A;
                  else begin
                     ps_opt_sum = ps_opt_sum + 16'(b[7:4]);
                     delta_done = 1'b1;
                  end
               end
            end
            PH_D13: begin
               ps_opt_sum = ps_opt_sum + EXT8_BASE + 16'(b);
               delta_done = 1'b1;
            end
            PH_D14A: begin
               ps_ext_hold = b;
               ps_phase    = PH_D14B;
            end
            PH_D14B: begin
               ps_opt_sum = ps_opt_sum + EXT16_BASE + {ps_ext_hold, b};
               delta_done = 1'b1;
            end
            PH_L13: begin
               opt_len  = EXT8_BASE + 16'(b);
               opt_done = 1'b1;
            end
            PH_L14A: begin
               ps_ext_hold = b;
               ps_phase    = PH_L14B;
            end
            PH_L14B: begin
               // wraps to 16 bits
               opt_len  = {ps_ext_hold, b} + EXT16_BASE;
               opt_done = 1'b1;
            end
            PH_VALUE: begin
               w               = '0;
               w.kind          = KIND_VALUE;
               w.data_value    = b;
               w.option_number = ps_opt_sum;
               w.item_index    = ps_opt_count - 5'd1;
               pending_words.push_back(w);
               if (ps_remaining > 0) ps_remaining = ps_remaining - 16'd1;
               if (ps_remaining == 0) ps_phase = PH_OPTION;
            end
            PH_PAYLOAD: begin
               w            = '0;
               w.kind       = KIND_PAYLOAD;
               w.data_value = b;
               pending_words.push_back(w);
               if (ps_pay_count < PAYLOAD_CAP) ps_pay_count = ps_pay_count + 11'd1;
            end
            default: ;
         endcase
      end

      // Delta settled: pick up the length, possibly from extension bytes.
      if (delta_done) begin
         if (ps_len_nib == NIBBLE_EXT8) ps_phase = PH_L13;
         else if (ps_len_nib == NIBBLE_EXT16) ps_phase = PH_L14A;
         else begin
            opt_len  = 16'(ps_len_nib);
            opt_done = 1'b1;
         end
      end

      if (opt_done) begin
         w               = '0;
         w.kind          = KIND_OPTION;
         w.option_number = ps_opt_sum;
         w.value_length  = opt_len;
         w.item_index    = ps_opt_count;
         pending_words.push_back(w);
         ps_opt_count = ps_opt_count + 5'd1;
         if (opt_len == 0) ps_phase = PH_OPTION;
         else begin
            ps_remaining = opt_len;
            ps_phase     = PH_VALUE;
         end
      end

      if (last) begin
         if (ps_phase == PH_HEADER || ps_phase == PH_TOKEN || ps_phase == PH_VALUE) err = 1'b1;
         w              = '0;
         w.kind         = KIND_FIN;
         w.value_length = 16'(ps_pay_count);
         w.item_index   = ps_opt_count;
         w.status       = err;
         pending_words.push_back(w);
         reset_parser();
      end

      if (pending_words.size() > first)
         pending_words[pending_words.size()-1].last_result = 1'b1;
   endfunction

   // Build one random message: mostly well formed, some noise, some cut short.
   function automatic void build_message();
      int unsigned tkl;
      int unsigned n_opts;
      int unsigned vlen;
      int unsigned pick;
      int unsigned cut;
      logic [3:0]  dn;
      logic [3:0]  ln;
      logic [7:0]  hi;
      logic [7:0]  lo;
      msg_bytes.delete();

      if ($urandom_range(0, 99) < 5) begin
         repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
         return;
      end

      tkl = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      msg_bytes.push_back({2'($urandom), 2'($urandom), 4'(tkl)});
      repeat (3) msg_bytes.push_back(8'($urandom));   // code, message id
      repeat (tkl) msg_bytes.push_back(8'($urandom));

      n_opts = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 4);
      repeat (n_opts) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) dn = NIBBLE_EXT8;
         else if (pick == 1) dn = NIBBLE_EXT16;
         else if (pick == 2) dn = 4'hF;
         else dn = 4'($urandom_range(0, 12));
         pick = $urandom_range(0, 39);
         if (pick < 4) ln = NIBBLE_EXT8;
         else if (pick == 4) ln = NIBBLE_EXT16;
         else if (pick < 8) ln = 4'hF;
         else ln = 4'($urandom_range(0, 4));
         msg_bytes.push_back({dn, ln});

         if (dn == NIBBLE_EXT8) msg_bytes.push_back(8'($urandom));
         if (dn == NIBBLE_EXT16) repeat (2) msg_bytes.push_back(8'($urandom));

         if (ln == NIBBLE_EXT8) begin
            lo = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
            msg_bytes.push_back(lo);
            vlen = 13 + lo;
         end else if (ln == NIBBLE_EXT16) begin
            // near-wrap lengths come out short; the rest are 268 bytes or longer
            pick = $urandom_range(0, 4);
            if (pick < 2) begin
               hi = 8'hFE;
               lo = 8'($urandom_range(8'hF3, 8'hFF));
            end else if (pick < 4) begin
               hi = 8'h00;
               lo = 8'($urandom);
            end else begin
               hi = 8'hFF;
               lo = 8'hFF;
            end
            msg_bytes.push_back(hi);
            msg_bytes.push_back(lo);
            vlen = 32'(16'({hi, lo} + EXT16_BASE));
         end else begin
            vlen = 32'(ln);
         end
         repeat (vlen) msg_bytes.push_back(8'($urandom));
      end

      if ($urandom_range(0, 1) == 1) begin
         msg_bytes.push_back(PAYLOAD_MARKER);
         repeat ($urandom_range(0, 16)) msg_bytes.push_back(8'($urandom));
      end else if (n_opts >= OPTION_LIMIT) begin
         // tail past the option limit that the parser skips
         repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
      end

      if ($urandom_range(0, 99) < 15) begin
         cut = $urandom_range(1, msg_bytes.size());
         while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
   endfunction

   // Offer one byte, after a random gap unless calm, hold it until taken, then predict.
   task automatic send_byte(input logic [7:0] b, input logic last, input bit calm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_byte(b, last);
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fault_count++;
      end
   endfunction

   // Compare one accepted result word against the oldest owed word.
   task automatic take_word();
      rsp_item_type want;
      if (pending_words.size() == 0) begin
         $display("%0t: unexpected result word, kind %0d, data %h", $time, rsp_tuser, rsp_tdata);
         fault_count++;
      end else begin
         want = pending_words.pop_front();
         check_field("kind", 16'(want.kind), 16'(rsp_tuser));
         check_field("version", 16'(want.version), 16'(rsp_tdata[1:0]));
         check_field("msg_type", 16'(want.msg_type), 16'(rsp_tdata[3:2]));
         check_field("token_length", 16'(want.token_length), 16'(rsp_tdata[7:4]));
         check_field("code", 16'(want.code), 16'(rsp_tdata[15:8]));
         check_field("message_id", want.message_id, rsp_tdata[31:16]);
         check_field("data_value", 16'(want.data_value), 16'(rsp_tdata[39:32]));
         check_field("option_number", want.option_number, rsp_tdata[55:40]);
         check_field("value_length", want.value_length, rsp_tdata[71:56]);
         check_field("item_index", 16'(want.item_index), 16'(rsp_tdata[76:72]));
         check_field("status", 16'(want.status), 16'(rsp_tdata[77]));
         check_field("pad", 16'd0, 16'(rsp_tdata[79:78]));
         check_field("last_result", 16'(want.last_result), 16'(rsp_tlast));
      end
   endtask

   // Receiver: take a word, then hold ready low for a random wait; drop
   // into runs of no waiting now and then, and obey the long hold-off.
   initial begin : drain
      int wait_left;
      bit calm;
      wait_left = 0;
      calm      = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            take_word();
            wait_left = calm ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 29) == 0) calm = !calm;
         end
         if (reset || stall_hold || wait_left > 0) begin
            rsp_tready <= 1'b0;
            if (wait_left > 0 && !stall_hold) wait_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Long hold-off on the result side while bytes keep coming, so the
   // result queue fills and the parser pushes back on its input.
   initial begin : hold_off
      repeat ($urandom_range(600, 1200)) @(posedge clock);
      stall_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      stall_hold <= 1'b0;
   end

   // Watchdog: end the run when no word moves on either side for too long.
   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int  sent;
      bit  calm;
      reset_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk the script; typed rows fix the end word.
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         send_byte(SCRIPT[i].data, SCRIPT[i].last, 1'b0);
         if (SCRIPT[i].typed) begin
            pending_words[pending_words.size()-1].status       = SCRIPT[i].status;
            pending_words[pending_words.size()-1].item_index   = SCRIPT[i].count;
            pending_words[pending_words.size()-1].value_length = SCRIPT[i].plen;
         end
      end

      // Random messages.
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         build_message();
         calm = ($urandom_range(0, 4) == 0);
         foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1, calm);
         sent += msg_bytes.size();
      end

      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
